// ----- sv/sptw_pkg.sv -----
// sptw_pkg: shared types, constants and helpers for the sv39 page table walker
// no dependencies; imported by sptw_table_mem, sptw_walker and sv39_page_table_walker

package sptw_pkg;

  // fixed geometry of an sv39 walk
  localparam int unsigned LEVELS         = 3;
  localparam int unsigned POOL_PAGES_DEF = 16;
  localparam int unsigned LVL_W          = 2;
  localparam int unsigned VPN_W          = 9;
  localparam int unsigned PAGE_OFF_W     = 12;
  localparam int unsigned PPN_W          = 44;
  localparam int unsigned VA_W           = 39;
  localparam int unsigned PA_W           = 56;
  localparam int unsigned PERM_W         = 8;
  localparam int unsigned ENTRY_W        = 64;

  // entry bit positions
  localparam int unsigned PTE_V_BIT   = 0;
  localparam int unsigned PTE_A_BIT   = 6;
  localparam int unsigned PTE_D_BIT   = 7;
  localparam int unsigned PTE_PPN_LSB = 10;
  localparam int unsigned PTE_PPN_MSB = PTE_PPN_LSB + PPN_W - 1;

  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_INSTALL   = 2'd1,
    CMD_UNINSTALL = 2'd2,
    CMD_ACCESS    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMAPPED  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_e;

  // one command word
  typedef struct packed {
    logic              dirty;
    logic [PERM_W-1:0] perm;
    logic [PA_W-1:0]   phys_addr;
    logic [VA_W-1:0]   vaddr;
    cmd_e              cmd;
  } item_t;

  // one result word plus its valid
  typedef struct packed {
    logic               valid;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [PA_W-1:0]    page_base;
    status_e            status;
  } result_t;

  // vpn field of a virtual address for a given level
  function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
                                             input logic [LVL_W-1:0] lvl);
    logic [VPN_W-1:0] vpn;
    case (lvl)
      2'd2:    vpn = va[38:30];
      2'd1:    vpn = va[29:21];
      default: vpn = va[20:12];
    endcase
    return vpn;
  endfunction

endpackage

// ----- sv/sptw_table_mem.sv -----
// sptw_table_mem: single-write, single-read synchronous table store
// depends on sptw_pkg for the entry width; registered read port, no reset

module sptw_table_mem import sptw_pkg::*; #(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF,
  parameter int unsigned ADDR_W     = $clog2(POOL_PAGES) + VPN_W
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = POOL_PAGES * (2 ** VPN_W);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sptw_walker.sv -----
// sptw_walker: command sequencer that walks, builds and updates the table store
// depends on sptw_pkg; drives the ports of sptw_table_mem and hands results upward

module sptw_walker import sptw_pkg::*; #(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF,
  parameter int unsigned ADDR_W     = $clog2(POOL_PAGES) + VPN_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PPN_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  item_t              in_item_i,
  output result_t            res_o,
  input  logic               res_ready_i,
  output logic               mem_we_o,
  output logic [ADDR_W-1:0]  mem_waddr_o,
  output logic [ENTRY_W-1:0] mem_wdata_o,
  output logic [ADDR_W-1:0]  mem_raddr_o,
  input  logic [ENTRY_W-1:0] mem_rdata_i
);

  localparam int unsigned PAGE_W = ADDR_W - VPN_W;
  localparam int unsigned CNT_W  = $clog2(POOL_PAGES + 1);
  localparam int unsigned DEPTH  = POOL_PAGES * (2 ** VPN_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [PPN_W-1:0]   base_q, base_d;
  item_t              item_q, item_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]   nfp_q, nfp_d;
  logic [PAGE_W-1:0]  np_q, np_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  status_e            status_q, status_d;
  logic [ENTRY_W-1:0] entry_q, entry_d;

  logic [ENTRY_W-1:0] rd_entry;
  logic [PPN_W-1:0]   ptr_off;
  logic [PPN_W-1:0]   link_ppn;
  logic [ENTRY_W-1:0] leaf_new;

  assign rd_entry = mem_rdata_i;
  assign ptr_off  = rd_entry[PTE_PPN_MSB:PTE_PPN_LSB] - base_q;
  assign link_ppn = base_q + PPN_W'(np_q);

  // next state, memory control and result
  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    item_d   = item_q;
    lvl_d    = lvl_q;
    page_d   = page_q;
    idx_d    = idx_q;
    nfp_d    = nfp_q;
    np_d     = np_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    entry_d  = entry_q;
    leaf_new = '0;

    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = '0;
    mem_raddr_o = {page_q, vpn_of(item_q.vaddr, lvl_q)};
    in_ready_o  = 1'b0;

    res_o.valid      = 1'b0;
    res_o.status     = status_q;
    res_o.leaf_entry = entry_q;
    res_o.page_base  = {entry_q[PTE_PPN_MSB:PTE_PPN_LSB], {PAGE_OFF_W{1'b0}}};

    if (cfg_we_i) begin
      base_d = cfg_wdata_i;
    end

    case (state_q)
      // zero the whole store after reset
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        cnt_d       = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_item_i;
          lvl_d   = LVL_W'(LEVELS - 1);
          page_d  = '0;
          state_d = S_READ;
        end
      end

      // issue the read for the current level
      S_READ: begin
        idx_d   = mem_raddr_o;
        state_d = S_EVAL;
      end

      // look at the entry read for this level
      S_EVAL: begin
        if (lvl_q == '0) begin
          state_d = S_DONE;
          if (item_q.cmd == CMD_INSTALL) begin
            leaf_new = {{(ENTRY_W - PTE_PPN_MSB - 1){1'b0}},
                        item_q.phys_addr[PA_W-1:PAGE_OFF_W],
                        {(PTE_PPN_LSB - PERM_W){1'b0}}, item_q.perm};
            leaf_new[PTE_V_BIT] = 1'b1;
            mem_we_o    = 1'b1;
            mem_wdata_o = leaf_new;
            status_d    = ST_OK;
            entry_d     = leaf_new;
          end else if (!rd_entry[PTE_V_BIT]) begin
            status_d = ST_UNMAPPED;
            entry_d  = '0;
          end else begin
            status_d = ST_OK;
            leaf_new = rd_entry;
            case (item_q.cmd)
              CMD_UNINSTALL: begin
                leaf_new[PTE_V_BIT] = 1'b0;
                mem_we_o = 1'b1;
              end
              CMD_ACCESS: begin
                leaf_new[PTE_A_BIT] = 1'b1;
                if (item_q.dirty) begin
                  leaf_new[PTE_D_BIT] = 1'b1;
                end
                mem_we_o = 1'b1;
              end
              default: begin
              end
            endcase
            mem_wdata_o = leaf_new;
            entry_d     = leaf_new;
          end
        end else if (!rd_entry[PTE_V_BIT]) begin
          // missing table: allocate for install, otherwise give up
          if (item_q.cmd == CMD_INSTALL && nfp_q != CNT_W'(POOL_PAGES)) begin
            np_d    = nfp_q[PAGE_W-1:0];
            nfp_d   = nfp_q + CNT_W'(1);
            cnt_d   = '0;
            state_d = S_ZERO;
          end else begin
            status_d = (item_q.cmd == CMD_INSTALL) ? ST_EXHAUSTED : ST_UNMAPPED;
            entry_d  = '0;
            state_d  = S_DONE;
          end
        end else if (ptr_off >= PPN_W'(POOL_PAGES)) begin
          status_d = ST_OUTSIDE;
          entry_d  = '0;
          state_d  = S_DONE;
        end else begin
          page_d  = ptr_off[PAGE_W-1:0];
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = S_READ;
        end
      end

      // zero the newly allocated table page, one entry a cycle
      S_ZERO: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = {np_q, cnt_q[VPN_W-1:0]};
        cnt_d       = cnt_q + ADDR_W'(1);
        if (cnt_q[VPN_W-1:0] == {VPN_W{1'b1}}) begin
          cnt_d   = '0;
          state_d = S_LINK;
        end
      end

      // write the pointer to the new table and descend into it
      S_LINK: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {{(ENTRY_W - PTE_PPN_MSB - 1){1'b0}}, link_ppn,
                       {(PTE_PPN_LSB - 1){1'b0}}, 1'b1};
        page_d      = np_q;
        lvl_d       = lvl_q - LVL_W'(1);
        state_d     = S_READ;
      end

      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      base_q  <= '0;
      nfp_q   <= CNT_W'(1);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      nfp_q   <= nfp_d;
      cnt_q   <= cnt_d;
    end
  end

  // walk payload
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    lvl_q    <= lvl_d;
    page_q   <= page_d;
    idx_q    <= idx_d;
    np_q     <= np_d;
    status_q <= status_d;
    entry_q  <= entry_d;
  end

  // allocator never passes the end of the pool
  a_nfp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfp_q <= CNT_W'(POOL_PAGES))
    else $error("table allocator beyond pool");

  // failed commands report an empty leaf
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != ST_OK) |-> (res_o.leaf_entry == '0))
    else $error("failed command with nonzero leaf");

  // no store write while waiting for a command
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_we_o)
    else $error("store written while idle");

  // a new table is linked only right after its zeroing sweep
  a_link_after_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> ($past(state_q) == S_ZERO))
    else $error("table linked without zeroing");

endmodule

// ----- sv/sv39_page_table_walker.sv -----
// sv39_page_table_walker: top level with stream ports, result register and table store
// depends on sptw_pkg, sptw_table_mem and sptw_walker
//
//   port group   dir   word contents
//   s_axis       in    one command: cmd, vaddr, phys_addr, perm, dirty
//   m_axis       out   one result: status, page_base, leaf_entry
//   cfg          in    pool_base_ppn write, taken on any cycle with cfg_we_i high
//
// a full three-level walk steps through accept, then a read and an evaluate state per level
// on the store's read port, then hand-off; a walk ending higher up leaves out the lower levels.
// install adds, for each table it creates, a 512-entry zeroing sweep plus the link write.
// after reset all POOL_PAGES * 512 entries of the store (8192 by default) are swept to zero;
// s_axis_tready stays low meanwhile. a waiting result holds the walker only at its
// final hand-off, and the next word is accepted while the output register is full.

module sv39_page_table_walker import sptw_pkg::*; #(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PPN_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [1:0] cmd, [40:2] vaddr, [96:41] phys_addr, [104:97] perm, [105] dirty
  input  logic [111:0]      s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [1:0] status, [57:2] page_base, [121:58] leaf_entry
  output logic [127:0]      m_axis_tdata
);

  localparam int unsigned ADDR_W = $clog2(POOL_PAGES) + VPN_W;
  localparam int unsigned IN_W   = $bits(item_t);
  localparam int unsigned OUT_W  = $bits(result_t) - 1;

  item_t              in_item;
  result_t            res;
  logic               res_ready;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;

  // unpack the command word
  assign in_item = item_t'(s_axis_tdata[IN_W-1:0]);

  sptw_table_mem #(
    .POOL_PAGES (POOL_PAGES),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sptw_walker #(
    .POOL_PAGES (POOL_PAGES),
    .ADDR_W     (ADDR_W)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = {res.leaf_entry, res.page_base, res.status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(128 - OUT_W){1'b0}}, out_data_q};

endmodule
